### sv/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Capacity, word and count types, operation and status codes, cell control.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DQ_CAPACITY = 64;
	localparam int WORD_W      = 32;
	localparam int CNT_W       = $clog2(DQ_CAPACITY + 1);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]         count_t;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_BACK  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_BACK   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic  exec;
		mode_t mode;
		word_t value;
	} cell_ctrl_t;

endpackage

### sv/dq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue row
// Holds one word and its valid flag; shifts with its neighbours on
// front operations, loads or drops locally on back operations.
// ----------------------------------------------------------------------------
module dq_cell
	import dq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  word_t      left_data,
	input  logic       left_valid,
	input  word_t      right_data,
	input  logic       right_valid,
	output word_t      data_q,
	output logic       valid_q
);

	logic  valid_d;
	word_t data_d;
	logic  data_en;

	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		data_en = 1'b0;
		if (ctrl.exec) begin
			unique case (ctrl.mode)
				MODE_PUSH_FRONT: begin
					data_d  = left_data;
					valid_d = left_valid;
					data_en = 1'b1;
				end
				MODE_PUSH_BACK: begin
					// first free cell takes the word
					if (left_valid && !valid_q) begin
						data_d  = ctrl.value;
						valid_d = 1'b1;
						data_en = 1'b1;
					end
				end
				MODE_POP_FRONT: begin
					data_d  = right_data;
					valid_d = right_valid;
					data_en = 1'b1;
				end
				MODE_POP_BACK: begin
					// last occupied cell lets go
					if (valid_q && !right_valid) begin
						valid_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (data_en) begin
			data_q <= data_d;
		end
	end

endmodule

### sv/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: fixed-capacity deque of signed 32-bit words
// A row of shifting cells keeps the front word in cell 0; each beat is one
// push or pop at either end and returns one result beat.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+----------------------------------
//  in      | in        | in_valid/in_stall   | mode[1:0], value[31:0]
//  out     | out       | out_valid/out_stall | popped[31:0], status[1:0],
//          |           |                     | occupancy[6:0]
//
//  The operation is applied to the cell row in the cycle it is accepted
//  and its result lands in the output register on that edge.
//  Sustained rate is one beat per cycle while the output side keeps up.
//  in_stall rises only while a result sits in the output register and the
//  output side is stalling, so at most one result is ever held.
//  Reset clears the cell valid flags, the count and the output valid; the
//  stored words themselves are not reset.
//
//  Front operations shift the whole row by one cell; back operations touch
//  only the cell at the boundary between occupied and free cells. A pop from
//  the back reads that boundary cell through an AND-OR select over the row.
// ----------------------------------------------------------------------------
module double_ended_queue
	import dq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic signed [31:0] value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [31:0] popped,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  occupancy
);

	// cell row
	word_t      cell_data  [DQ_CAPACITY];
	logic       cell_valid [DQ_CAPACITY];
	cell_ctrl_t ctrl;

	// control and count
	logic    accept;
	logic    full;
	logic    empty;
	mode_t   op;
	status_t status_d;
	word_t   popped_d;
	word_t   back_word;
	count_t  count_q;
	count_t  count_d;

	// output register
	logic    out_valid_q;
	word_t   popped_q;
	status_t status_q;
	count_t  occupancy_q;

	assign op       = mode_t'(mode);
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// occupancy seen directly at the row's ends
	assign full  = cell_valid[DQ_CAPACITY-1];
	assign empty = !cell_valid[0];

	// word in the last occupied cell
	always_comb begin
		back_word = '0;
		for (int i = 0; i < DQ_CAPACITY; i++) begin
			if (cell_valid[i] && ((i == DQ_CAPACITY - 1) || !cell_valid[(i + 1) % DQ_CAPACITY]))
				back_word = back_word | cell_data[i];
		end
	end

	// decode: refused operations leave the row and count alone
	always_comb begin
		status_d  = ST_OK;
		popped_d  = '0;
		count_d   = count_q;
		ctrl.exec = 1'b0;
		ctrl.mode = op;
		ctrl.value = value;
		unique case (op)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.exec = accept;
					count_d   = count_q + count_t'(1);
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.exec = accept;
					count_d   = count_q - count_t'(1);
					popped_d  = (op == MODE_POP_FRONT) ? cell_data[0] : back_word;
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar g = 0; g < DQ_CAPACITY; g++) begin : g_cell
		word_t lft_data;
		logic  lft_valid;
		word_t rgt_data;
		logic  rgt_valid;

		if (g == 0) begin : g_first
			assign lft_data  = value;
			assign lft_valid = 1'b1;
		end else begin : g_inner_l
			assign lft_data  = cell_data[g-1];
			assign lft_valid = cell_valid[g-1];
		end

		if (g == DQ_CAPACITY - 1) begin : g_last
			assign rgt_data  = '0;
			assign rgt_valid = 1'b0;
		end else begin : g_inner_r
			assign rgt_data  = cell_data[g+1];
			assign rgt_valid = cell_valid[g+1];
		end

		dq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_data   (lft_data),
			.left_valid  (lft_valid),
			.right_data  (rgt_data),
			.right_valid (rgt_valid),
			.data_q      (cell_data[g]),
			.valid_q     (cell_valid[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q    <= popped_d;
			status_q    <= status_d;
			occupancy_q <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign popped    = popped_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;

endmodule

### sv/dq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the double-ended queue
// Watches result beats for consistent status, occupancy and hold behaviour.
// ----------------------------------------------------------------------------
module dq_checker
	import dq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [31:0] popped,
	input logic [1:0]        status,
	input logic [CNT_W-1:0]  occupancy
);

	// input side only backs off while a result is held
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without a held result");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= CNT_W'(DQ_CAPACITY)))
		else $error("occupancy beyond capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (occupancy == CNT_W'(DQ_CAPACITY) && popped == 0))
		else $error("full status with room left");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (occupancy == 0 && popped == 0))
		else $error("empty status on non-empty queue");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(popped) && $stable(status)
			&& $stable(occupancy)))
		else $error("stalled result beat changed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the double-ended queue
// Drives push and pop beats at both ends under random idling and stalls,
// mirrors the deque in a local shadow copy and checks every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	import dq_pkg::*;

	// ------------------------------------------------------------------------
	// Clock, reset and the block's ports
	// ------------------------------------------------------------------------
	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       mode;
	logic signed [31:0] value;
	logic             out_valid;
	logic             out_stall;
	logic signed [31:0] popped;
	logic [1:0]       status;
	logic [CNT_W-1:0] occupancy;

	localparam int N_ITEMS     = 1250;
	localparam int IDLE_PCT    = 13;
	localparam int QUIET_LIMIT = 1000;  // cycles with no beat on either side
	localparam int MAX_REPORTS = 10;
	localparam int CALM_FROM   = 600;   // window with no idling on either side
	localparam int CALM_TO     = 1000;

	double_ended_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.popped    (popped),
		.status    (status),
		.occupancy (occupancy)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Stimulus and expectation stores
	// ------------------------------------------------------------------------
	// A pending entry is either an operation or a hold-off marker: at a marker
	// the driver keeps in_valid low until every outstanding result is back.
	typedef struct {
		bit    hold_off;
		mode_t op;
		word_t w;
	} dq_item_t;

	typedef struct {
		mode_t   op;
		word_t   popped;
		status_t st;
		count_t  occ;
	} dq_result_t;

	dq_item_t   pending[$];
	dq_result_t results_due[$];

	// ------------------------------------------------------------------------
	// Shadow deque: circular store, head position and fill level
	// ------------------------------------------------------------------------
	word_t ring [DQ_CAPACITY];
	int    head;
	int    held;

	// Applies one operation to the shadow deque and returns the result beat
	// the block should give for it.
	function automatic dq_result_t deque_apply(mode_t op, word_t w);
		dq_result_t r;
		r.op     = op;
		r.popped = '0;
		r.st     = ST_OK;
		if (op == MODE_PUSH_FRONT || op == MODE_PUSH_BACK) begin
			if (held >= DQ_CAPACITY) begin
				r.st = ST_FULL;
			end else if (op == MODE_PUSH_FRONT) begin
				head = (head + DQ_CAPACITY - 1) % DQ_CAPACITY;
				ring[head] = w;
				held++;
			end else begin
				ring[(head + held) % DQ_CAPACITY] = w;
				held++;
			end
		end else if (held == 0) begin
			r.st = ST_EMPTY;
		end else begin
			if (op == MODE_POP_FRONT) begin
				r.popped = ring[head];
				head = (head + 1) % DQ_CAPACITY;
			end else begin
				r.popped = ring[(head + held - 1) % DQ_CAPACITY];
			end
			held--;
			// emptied: front position goes back to the start
			if (held == 0)
				head = 0;
		end
		r.occ = count_t'(held);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------------
	// gen_held follows the fill level only so that phases can be steered
	// towards full and empty; it plays no part in checking.
	int n_gen;
	int gen_held;

	task automatic add_op(input mode_t op, input word_t w);
		dq_item_t it;
		it.hold_off = 1'b0;
		it.op       = op;
		it.w        = w;
		pending.push_back(it);
		n_gen++;
		if (op == MODE_PUSH_FRONT || op == MODE_PUSH_BACK) begin
			if (gen_held < DQ_CAPACITY)
				gen_held++;
		end else if (gen_held > 0) begin
			gen_held--;
		end
	endtask

	task automatic add_hold_off();
		dq_item_t it;
		it.hold_off = 1'b1;
		it.op       = MODE_PUSH_BACK;
		it.w        = '0;
		pending.push_back(it);
	endtask

	// mostly full-range random words, with the extremes now and then
	function automatic word_t rand_word();
		word_t w;
		case ($urandom_range(0, 9))
			0: w = 32'sh8000_0000;
			1: w = 32'sh7FFF_FFFF;
			2: w = '0;
			3: w = -32'sd1;
			default: w = word_t'($urandom);
		endcase
		return w;
	endfunction

	// One phase of random traffic; push_pct steers it towards full or empty.
	task automatic add_phase(input int len, input int push_pct);
		bit    do_push;
		bit    at_back;
		mode_t op;
		for (int i = 0; i < len; i++) begin
			do_push = ($urandom_range(0, 99) < push_pct);
			at_back = $urandom_range(0, 1);
			if (do_push)
				op = at_back ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
			else
				op = at_back ? MODE_POP_BACK : MODE_POP_FRONT;
			add_op(op, rand_word());
		end
	endtask

	// ------------------------------------------------------------------------
	// Cycle count and the calm window
	// ------------------------------------------------------------------------
	int cyc;
	bit calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
		end
	end

	assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	// ------------------------------------------------------------------------
	// Driver: input side and output stall, both changed on the falling edge
	// ------------------------------------------------------------------------
	bit in_took;   // the input beat on show was taken at the last rising edge

	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
			// a new beat is only offered once the previous one has gone
			if (!in_valid || in_took) begin
				if (pending.size() != 0 && pending[0].hold_off) begin
					in_valid <= 1'b0;
					if (results_due.size() == 0)
						void'(pending.pop_front());
				end else if (pending.size() != 0 &&
						(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					mode     <= pending[0].op;
					value    <= pending[0].w;
					void'(pending.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: sample both channels on the rising edge
	// ------------------------------------------------------------------------
	// Results are checked before the input beat of the same edge is predicted;
	// the result of a beat can at the earliest be taken at the following edge.
	int n_in;
	int n_out;
	int n_bad;
	int n_full;
	int n_empty;
	int n_pops;
	int peak;

	always @(posedge clk) begin
		dq_result_t due;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				n_out++;
				if (results_due.size() == 0) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS)
						$display("%0t: result beat with nothing due: popped %0d status %0d occ %0d",
							$realtime, popped, status, occupancy);
				end else begin
					due = results_due.pop_front();
					if (popped !== due.popped || status !== due.st || occupancy !== due.occ) begin
						n_bad++;
						if (n_bad <= MAX_REPORTS)
							$display("%0t: %s mismatch: popped %0d/%0d status %0d/%0d occ %0d/%0d (exp/got)",
								$realtime, due.op.name(), due.popped, popped,
								due.st, status, due.occ, occupancy);
					end
				end
			end
			if (in_valid && !in_stall) begin
				due = deque_apply(mode_t'(mode), value);
				results_due.push_back(due);
				n_in++;
				if (due.st == ST_FULL)
					n_full++;
				if (due.st == ST_EMPTY)
					n_empty++;
				if (due.st == ST_OK && (due.op == MODE_POP_FRONT || due.op == MODE_POP_BACK))
					n_pops++;
				if (int'(due.occ) > peak)
					peak = int'(due.occ);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long without a beat on either side ends the run
	// ------------------------------------------------------------------------
	int quiet;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results still due",
					quiet, results_due.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus plan, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = MODE_PUSH_FRONT;
		value     = '0;
		out_stall = 1'b0;
		head      = 0;
		held      = 0;
		n_gen     = 0;
		gen_held  = 0;
		quiet     = 0;
		n_in      = 0;
		n_out     = 0;
		n_bad     = 0;
		n_full    = 0;
		n_empty   = 0;
		n_pops    = 0;
		peak      = 0;

		// directed: refused pops on empty, extremes through both ends
		add_op(MODE_POP_FRONT, 32'sd5);
		add_op(MODE_POP_BACK, -32'sd5);
		add_op(MODE_PUSH_BACK, 32'sh7FFF_FFFF);
		add_op(MODE_PUSH_FRONT, 32'sh8000_0000);
		add_op(MODE_PUSH_BACK, -32'sd1);
		add_op(MODE_PUSH_FRONT, '0);
		add_op(MODE_POP_BACK, '0);
		add_op(MODE_POP_FRONT, '0);
		add_op(MODE_POP_BACK, '0);
		add_op(MODE_POP_FRONT, '0);      // drains: front goes back to start
		add_op(MODE_POP_BACK, '0);       // empty again
		// front push on empty wraps the head round the store
		add_op(MODE_PUSH_FRONT, 32'sh5555_5555);
		add_op(MODE_PUSH_BACK, 32'shAAAA_AAAA);
		add_op(MODE_POP_FRONT, '0);
		add_op(MODE_POP_FRONT, '0);
		add_op(MODE_PUSH_BACK, 32'sd1);
		add_op(MODE_POP_BACK, '0);
		add_hold_off();

		// random: first run up to full and past it, then mixed phases
		add_phase(100, 95);
		add_phase(30, 60);
		add_phase(100, 5);
		for (int ph = 0; n_gen < N_ITEMS; ph++) begin
			case ($urandom_range(0, 3))
				0: add_phase($urandom_range(20, 120), (gen_held < 40) ? 90 : 60);
				1: add_phase($urandom_range(20, 120), (gen_held > 24) ? 10 : 40);
				2: add_phase($urandom_range(20, 80), 50);
				default: add_phase($urandom_range(10, 40), 70);
			endcase
			if (ph % 5 == 4)
				add_hold_off();
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d operations, %0d results, %0d words popped, peak fill %0d of %0d",
			n_in, n_out, n_pops, peak, DQ_CAPACITY);
		$display("Refused: %0d pushes when full, %0d pops when empty; %0d mismatches",
			n_full, n_empty, n_bad);
		if (n_bad == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
